### src/bpa_pkg.sv
// Package for the buddy page allocator: request/response types, page memory
// word, memory write request and shared constants. No dependencies.
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int ORDER_CAP  = 10;
    localparam int NUM_ORDERS = ORDER_CAP + 1;
    localparam int PAGE_W     = ORDER_CAP;
    localparam int NUM_PAGES  = 1 << ORDER_CAP;
    localparam int LINK_W     = PAGE_W + 1;   // top bit set means no page
    localparam int ORD_W      = 4;
    localparam int CNT_W      = ORDER_CAP + 1;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(1) << PAGE_W;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    typedef struct packed {
        logic             cmd;
        logic [10:0]      page_count;
        logic [9:0]       page_index;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [9:0]       block_index;
        logic [10:0]      pages_left;
    } rsp_t;

    typedef struct packed {
        logic [LINK_W-1:0] next_pg;
        logic [LINK_W-1:0] prev_pg;
        logic              fh;        // head of a free block
        logic              ah;        // head of an allocated block
        logic [ORD_W-1:0]  ord;
    } page_t;

    typedef struct packed {
        logic              en;
        logic [PAGE_W-1:0] addr;
        logic              we_next;
        logic              we_prev;
        logic              we_fh;
        logic              we_ah;
        logic              we_ord;
        page_t             data;
    } mem_wr_t;

    typedef struct packed {
        logic             valid;
        logic [ORD_W-1:0] order;
    } cfg_wr_t;

    typedef struct packed {
        logic idle;       // ready for a new request
        logic cfg_ok;     // pool order may be rewritten
        logic done;       // result waiting
    } seq_stat_t;

    // Smallest o with 2^o >= n, n >= 1.
    function automatic logic [ORD_W-1:0] ceil_order(input logic [10:0] n);
        logic [ORD_W-1:0] res;
        res = ORD_W'(11);
        for (int o = 11; o >= 0; o--) begin
            if ((12'd1 << o) >= {1'b0, n})
                res = ORD_W'(o);
        end
        return res;
    endfunction

endpackage

### src/buddy_page_allocator_top.sv
// Top level of the buddy page allocator: request/response handshakes,
// response register and pool order port. Uses bpa_pkg, bpa_seq.
`timescale 1ns / 1ps

// Buddy allocator over 2^pool_order pages (pool_order 0..10, reset 10). One
// request at a time: allocate (cmd 0) rounds page_count up to a power of two;
// free (cmd 1) returns a block and merges it with its buddies. Every request
// gives one response. Per-page state lives in a 1024-word page memory with one
// read and one write per cycle, so each split or merge level is a sequence of
// memory reads and writes; rejected requests finish sooner. After reset and
// after every pool_order write the memory is cleared in a pass over all 1024
// pages during which no request is taken; pool_order writes are taken whenever
// no request is in progress, and a request waits while a write is offered.
// Values above 10 act as 10.
module buddy_page_allocator_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bpa_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bpa_pkg::rsp_t  rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [3:0]     cfg_data
);
    import bpa_pkg::*;

    seq_stat_t stat;
    rsp_t      res;
    cfg_wr_t   cfg_wr;
    logic      start;
    logic      res_take;
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_t      rsp_reg;

    // a pool_order write wins over a request offered in the same cycle
    assign req_stall    = !stat.idle || cfg_valid;
    assign start        = req_valid && !req_stall;
    assign cfg_ready    = stat.cfg_ok;
    assign cfg_wr.valid = cfg_valid && stat.cfg_ok;
    assign cfg_wr.order = cfg_data;

    // response slot frees up in the same cycle it is taken
    assign res_take       = stat.done && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid_next = res_take || (rsp_valid_reg && rsp_stall);

    bpa_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .start    (start),
        .req      (req),
        .res_take (res_take),
        .res      (res),
        .stat     (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            rsp_reg <= res;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### src/bpa_page_mem.sv
// Per-page state memory: links, flags and order, one word per page.
// Per-field write enables, one registered read port. Uses bpa_pkg.
`timescale 1ns / 1ps

module bpa_page_mem (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [bpa_pkg::PAGE_W-1:0]  rd_addr,
    output bpa_pkg::page_t              rd_data,
    input  bpa_pkg::mem_wr_t            wr
);
    import bpa_pkg::*;

    page_t mem [0:NUM_PAGES-1];
    page_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            if (wr.we_next) mem[wr.addr].next_pg <= wr.data.next_pg;
            if (wr.we_prev) mem[wr.addr].prev_pg <= wr.data.prev_pg;
            if (wr.we_fh)   mem[wr.addr].fh      <= wr.data.fh;
            if (wr.we_ah)   mem[wr.addr].ah      <= wr.data.ah;
            if (wr.we_ord)  mem[wr.addr].ord     <= wr.data.ord;
        end
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/bpa_seq.sv
// Allocation sequencer: free list heads, free count, pool order and the
// split / merge state machine around the page memory. Uses bpa_pkg, bpa_page_mem.
`timescale 1ns / 1ps

module bpa_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bpa_pkg::cfg_wr_t     cfg_wr,
    input  logic                 start,
    input  bpa_pkg::req_t        req,
    input  logic                 res_take,
    output bpa_pkg::rsp_t        res,
    output bpa_pkg::seq_stat_t   stat
);
    import bpa_pkg::*;

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_CHECK    = 5'd2;
    localparam logic [4:0] S_SPL_RD   = 5'd3;
    localparam logic [4:0] S_SPL_W0   = 5'd4;
    localparam logic [4:0] S_SPL_W1   = 5'd5;
    localparam logic [4:0] S_SPL_W2   = 5'd6;
    localparam logic [4:0] S_SPL_W3   = 5'd7;
    localparam logic [4:0] S_TAKE_RD  = 5'd8;
    localparam logic [4:0] S_TAKE_W0  = 5'd9;
    localparam logic [4:0] S_TAKE_W1  = 5'd10;
    localparam logic [4:0] S_FCHK     = 5'd11;
    localparam logic [4:0] S_MRG_TEST = 5'd12;
    localparam logic [4:0] S_MRG_CHK  = 5'd13;
    localparam logic [4:0] S_MRG_W1   = 5'd14;
    localparam logic [4:0] S_MRG_W2   = 5'd15;
    localparam logic [4:0] S_PUSH0    = 5'd16;
    localparam logic [4:0] S_PUSH1    = 5'd17;
    localparam logic [4:0] S_DONE     = 5'd18;

    logic [4:0]        state_reg, state_next;
    logic [ORD_W-1:0]  pool_reg, pool_next;
    logic [LINK_W-1:0] head_reg [0:ORDER_CAP];
    logic [LINK_W-1:0] head_next [0:ORDER_CAP];
    logic [CNT_W-1:0]  fcnt_reg, fcnt_next;
    logic [PAGE_W-1:0] clr_reg, clr_next;

    logic              cmd_reg, cmd_next;
    logic [10:0]       n_reg, n_next;
    logic [PAGE_W-1:0] base_reg, base_next;
    logic [ORD_W-1:0]  o_reg, o_next;
    logic [ORD_W-1:0]  lvl_reg, lvl_next;
    logic [PAGE_W-1:0] a_reg, a_next;
    logic [PAGE_W-1:0] b_reg, b_next;
    logic [LINK_W-1:0] h_reg, h_next;
    logic [LINK_W-1:0] pr_reg, pr_next;
    logic [LINK_W-1:0] nx_reg, nx_next;
    logic [1:0]        st_reg, st_next;
    logic [PAGE_W-1:0] blk_reg, blk_next;

    logic              rd_en;
    logic [PAGE_W-1:0] rd_addr;
    page_t             rd_data;
    mem_wr_t           wr;

    logic              found;
    logic [ORD_W-1:0]  found_lvl;
    logic [ORD_W-1:0]  lvl_dn;
    logic [PAGE_W-1:0] head_pg;
    logic [CNT_W-1:0]  pool_pages;
    logic [CNT_W-1:0]  mask;
    logic [10:0]       n_eff;
    logic [ORD_W-1:0]  sat_order;

    bpa_page_mem u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    assign lvl_dn     = lvl_reg - ORD_W'(1);
    assign pool_pages = CNT_W'(1) << pool_reg;
    assign mask       = (CNT_W'(1) << rd_data.ord) - CNT_W'(1);
    assign n_eff      = (req.page_count == 11'd0) ? 11'd1 : req.page_count;
    assign sat_order  = (cfg_wr.order > ORD_W'(ORDER_CAP)) ? ORD_W'(ORDER_CAP)
                                                           : cfg_wr.order;

    // smallest non-empty list at or above the requested order
    always_comb
    begin
        found     = 1'b0;
        found_lvl = '0;
        for (int i = ORDER_CAP; i >= 0; i--) begin
            if (ORD_W'(i) >= o_reg && ORD_W'(i) <= pool_reg && !head_reg[i][PAGE_W])
            begin
                found     = 1'b1;
                found_lvl = ORD_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pool_next  = pool_reg;
        head_next  = head_reg;
        fcnt_next  = fcnt_reg;
        clr_next   = clr_reg;
        cmd_next   = cmd_reg;
        n_next     = n_reg;
        base_next  = base_reg;
        o_next     = o_reg;
        lvl_next   = lvl_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        h_next     = h_reg;
        pr_next    = pr_reg;
        nx_next    = nx_reg;
        st_next    = st_reg;
        blk_next   = blk_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr         = '0;
        head_pg    = '0;

        case (state_reg)
            S_CLEAR:
            begin
                wr.en      = 1'b1;
                wr.addr    = clr_reg;
                wr.we_next = 1'b1;
                wr.we_prev = 1'b1;
                wr.we_fh   = 1'b1;
                wr.we_ah   = 1'b1;
                wr.we_ord  = 1'b1;
                wr.data.next_pg = NULL_LINK;
                wr.data.prev_pg = NULL_LINK;
                wr.data.fh      = (clr_reg == '0);
                wr.data.ah      = 1'b0;
                wr.data.ord     = (clr_reg == '0) ? pool_reg : '0;
                clr_next = clr_reg + PAGE_W'(1);
                if (clr_reg == {PAGE_W{1'b1}})
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = req.cmd;
                    n_next     = n_eff;
                    base_next  = req.page_index;
                    o_next     = ceil_order(n_eff);
                    blk_next   = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (n_reg > fcnt_reg || o_reg > pool_reg || !found)
                    begin
                        st_next    = ST_NOMEM;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        lvl_next   = found_lvl;
                        state_next = (found_lvl == o_reg) ? S_TAKE_RD : S_SPL_RD;
                    end
                end
                else if ({1'b0, base_reg} >= pool_pages)
                begin
                    st_next    = ST_BADFREE;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = base_reg;
                    state_next = S_FCHK;
                end
            end
            S_SPL_RD:
            begin
                head_pg    = head_reg[lvl_reg][PAGE_W-1:0];
                a_next     = head_pg;
                rd_en      = 1'b1;
                rd_addr    = head_pg;
                state_next = S_SPL_W0;
            end
            S_SPL_W0:
            begin
                // a was the list head: pop it
                head_next[lvl_reg] = rd_data.next_pg;
                if (!rd_data.next_pg[PAGE_W])
                begin
                    wr.en           = 1'b1;
                    wr.addr         = rd_data.next_pg[PAGE_W-1:0];
                    wr.we_prev      = 1'b1;
                    wr.data.prev_pg = NULL_LINK;
                end
                state_next = S_SPL_W1;
            end
            S_SPL_W1:
            begin
                b_next     = a_reg + (PAGE_W'(1) << lvl_dn);
                wr.en      = 1'b1;
                wr.addr    = a_reg;
                wr.we_next = 1'b1;
                wr.we_prev = 1'b1;
                wr.we_fh   = 1'b1;
                wr.we_ah   = 1'b1;
                wr.we_ord  = 1'b1;
                wr.data.next_pg = {1'b0, a_reg + (PAGE_W'(1) << lvl_dn)};
                wr.data.prev_pg = NULL_LINK;
                wr.data.fh      = 1'b1;
                wr.data.ah      = 1'b0;
                wr.data.ord     = lvl_dn;
                state_next = S_SPL_W2;
            end
            S_SPL_W2:
            begin
                h_next     = head_reg[lvl_dn];
                wr.en      = 1'b1;
                wr.addr    = b_reg;
                wr.we_next = 1'b1;
                wr.we_prev = 1'b1;
                wr.we_fh   = 1'b1;
                wr.we_ah   = 1'b1;
                wr.we_ord  = 1'b1;
                wr.data.next_pg = head_reg[lvl_dn];
                wr.data.prev_pg = {1'b0, a_reg};
                wr.data.fh      = 1'b1;
                wr.data.ah      = 1'b0;
                wr.data.ord     = lvl_dn;
                head_next[lvl_dn] = {1'b0, a_reg};
                if (!head_reg[lvl_dn][PAGE_W])
                    state_next = S_SPL_W3;
                else
                begin
                    lvl_next   = lvl_dn;
                    state_next = (lvl_dn == o_reg) ? S_TAKE_RD : S_SPL_RD;
                end
            end
            S_SPL_W3:
            begin
                wr.en           = 1'b1;
                wr.addr         = h_reg[PAGE_W-1:0];
                wr.we_prev      = 1'b1;
                wr.data.prev_pg = {1'b0, b_reg};
                lvl_next        = lvl_dn;
                state_next      = (lvl_dn == o_reg) ? S_TAKE_RD : S_SPL_RD;
            end
            S_TAKE_RD:
            begin
                head_pg    = head_reg[o_reg][PAGE_W-1:0];
                a_next     = head_pg;
                rd_en      = 1'b1;
                rd_addr    = head_pg;
                state_next = S_TAKE_W0;
            end
            S_TAKE_W0:
            begin
                head_next[o_reg] = rd_data.next_pg;
                if (!rd_data.next_pg[PAGE_W])
                begin
                    wr.en           = 1'b1;
                    wr.addr         = rd_data.next_pg[PAGE_W-1:0];
                    wr.we_prev      = 1'b1;
                    wr.data.prev_pg = NULL_LINK;
                end
                state_next = S_TAKE_W1;
            end
            S_TAKE_W1:
            begin
                wr.en      = 1'b1;
                wr.addr    = a_reg;
                wr.we_fh   = 1'b1;
                wr.we_ah   = 1'b1;
                wr.data.fh = 1'b0;
                wr.data.ah = 1'b1;
                fcnt_next  = fcnt_reg - (CNT_W'(1) << o_reg);
                st_next    = ST_OK;
                blk_next   = a_reg;
                state_next = S_DONE;
            end
            S_FCHK:
            begin
                if (!rd_data.ah || rd_data.ord > pool_reg
                    || ({1'b0, base_reg} & mask) != '0 || o_reg != rd_data.ord)
                begin
                    st_next    = ST_BADFREE;
                    state_next = S_DONE;
                end
                else
                begin
                    fcnt_next  = fcnt_reg + (CNT_W'(1) << rd_data.ord);
                    a_next     = base_reg;
                    state_next = S_MRG_TEST;
                end
            end
            S_MRG_TEST:
            begin
                // the block being freed stays off its list until merging ends
                if (o_reg < pool_reg)
                begin
                    b_next     = a_reg ^ (PAGE_W'(1) << o_reg);
                    rd_en      = 1'b1;
                    rd_addr    = a_reg ^ (PAGE_W'(1) << o_reg);
                    state_next = S_MRG_CHK;
                end
                else
                    state_next = S_PUSH0;
            end
            S_MRG_CHK:
            begin
                if (!rd_data.fh || rd_data.ord != o_reg)
                    state_next = S_PUSH0;
                else
                begin
                    pr_next = rd_data.prev_pg;
                    nx_next = rd_data.next_pg;
                    if (!rd_data.prev_pg[PAGE_W])
                    begin
                        wr.en           = 1'b1;
                        wr.addr         = rd_data.prev_pg[PAGE_W-1:0];
                        wr.we_next      = 1'b1;
                        wr.data.next_pg = rd_data.next_pg;
                    end
                    else
                        head_next[o_reg] = rd_data.next_pg;
                    state_next = S_MRG_W1;
                end
            end
            S_MRG_W1:
            begin
                if (!nx_reg[PAGE_W])
                begin
                    wr.en           = 1'b1;
                    wr.addr         = nx_reg[PAGE_W-1:0];
                    wr.we_prev      = 1'b1;
                    wr.data.prev_pg = pr_reg;
                end
                state_next = S_MRG_W2;
            end
            S_MRG_W2:
            begin
                // upper half loses its head marks
                wr.en      = 1'b1;
                wr.addr    = (a_reg > b_reg) ? a_reg : b_reg;
                wr.we_fh   = 1'b1;
                wr.we_ah   = 1'b1;
                wr.data.fh = 1'b0;
                wr.data.ah = 1'b0;
                a_next     = (a_reg < b_reg) ? a_reg : b_reg;
                o_next     = o_reg + ORD_W'(1);
                state_next = S_MRG_TEST;
            end
            S_PUSH0:
            begin
                h_next     = head_reg[o_reg];
                wr.en      = 1'b1;
                wr.addr    = a_reg;
                wr.we_next = 1'b1;
                wr.we_prev = 1'b1;
                wr.we_fh   = 1'b1;
                wr.we_ah   = 1'b1;
                wr.we_ord  = 1'b1;
                wr.data.next_pg = head_reg[o_reg];
                wr.data.prev_pg = NULL_LINK;
                wr.data.fh      = 1'b1;
                wr.data.ah      = 1'b0;
                wr.data.ord     = o_reg;
                head_next[o_reg] = {1'b0, a_reg};
                st_next    = ST_OK;
                state_next = head_reg[o_reg][PAGE_W] ? S_DONE : S_PUSH1;
            end
            S_PUSH1:
            begin
                wr.en           = 1'b1;
                wr.addr         = h_reg[PAGE_W-1:0];
                wr.we_prev      = 1'b1;
                wr.data.prev_pg = {1'b0, a_reg};
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // pool reinit: one free block at page 0, then a clearing pass
        if (cfg_wr.valid)
        begin
            pool_next = sat_order;
            for (int i = 0; i <= ORDER_CAP; i++)
                head_next[i] = NULL_LINK;
            head_next[sat_order] = '0;
            fcnt_next  = CNT_W'(1) << sat_order;
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pool_reg  <= ORD_W'(ORDER_CAP);
            for (int i = 0; i <= ORDER_CAP; i++)
                head_reg[i] <= (i == ORDER_CAP) ? '0 : NULL_LINK;
            fcnt_reg  <= CNT_W'(1) << ORDER_CAP;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pool_reg  <= pool_next;
            head_reg  <= head_next;
            fcnt_reg  <= fcnt_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        n_reg    <= n_next;
        base_reg <= base_next;
        o_reg    <= o_next;
        lvl_reg  <= lvl_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        h_reg    <= h_next;
        pr_reg   <= pr_next;
        nx_reg   <= nx_next;
        st_reg   <= st_next;
        blk_reg  <= blk_next;
    end

    assign res.status      = st_reg;
    assign res.block_index = blk_reg;
    assign res.pages_left  = fcnt_reg;

    assign stat.idle   = (state_reg == S_IDLE);
    assign stat.cfg_ok = (state_reg == S_IDLE) || (state_reg == S_CLEAR);
    assign stat.done   = (state_reg == S_DONE);

endmodule

### tb/tb_buddy_page_allocator_top.sv
// Testbench for buddy_page_allocator_top: random and directed allocate/free
// requests checked against a behavioral page pool model. Uses bpa_pkg.
`timescale 1ns / 1ps

import bpa_pkg::*;

class page_pool_model;
    int    pool_ord;
    int    head[NUM_ORDERS];
    int    nxt[NUM_PAGES];
    int    prv[NUM_PAGES];
    bit    fh[NUM_PAGES];
    bit    ah[NUM_PAGES];
    int    ord[NUM_PAGES];
    int    free_cnt;
    int    errors;
    int    live_base[$];
    int    live_ord[$];
    rsp_t  pending_rsp[$];

    function new();
        errors = 0;
        reinit(ORDER_CAP);
    endfunction

    function void reinit(int o);
        pool_ord = (o > ORDER_CAP) ? ORDER_CAP : o;
        foreach (head[i]) head[i] = -1;
        foreach (fh[i])
        begin
            fh[i] = 0; ah[i] = 0; ord[i] = 0; nxt[i] = -1; prv[i] = -1;
        end
        live_base.delete();
        live_ord.delete();
        push(pool_ord, 0);
        fh[0] = 1;
        ord[0] = pool_ord;
        free_cnt = 1 << pool_ord;
    endfunction

    function void push(int o, int p);
        nxt[p] = head[o];
        prv[p] = -1;
        if (head[o] >= 0) prv[head[o]] = p;
        head[o] = p;
    endfunction

    function void unlink(int o, int p);
        if (prv[p] >= 0) nxt[prv[p]] = nxt[p];
        else head[o] = nxt[p];
        if (nxt[p] >= 0) prv[nxt[p]] = prv[p];
    endfunction

    function int log2_up(int n);
        int o;
        o = 0;
        while (o < 12 && (1 << o) < n) o++;
        return o;
    endfunction

    function logic [1:0] take_block(int n, output int p);
        int o, i, a, b;
        o = log2_up(n);
        p = 0;
        if (n > free_cnt || o > pool_ord) return ST_NOMEM;
        while (head[o] < 0)
        begin
            for (i = o + 1; i <= pool_ord; i++)
                if (head[i] >= 0) break;
            if (i > pool_ord) return ST_NOMEM;
            // split: lower half to list head, buddy right behind it
            a = head[i];
            b = a + (1 << (i - 1));
            unlink(i, a);
            ord[a] = i - 1; ord[b] = i - 1;
            fh[a] = 1; fh[b] = 1;
            push(i - 1, a);
            nxt[b] = nxt[a];
            prv[b] = a;
            if (nxt[a] >= 0) prv[nxt[a]] = b;
            nxt[a] = b;
        end
        p = head[o];
        unlink(o, p);
        fh[p] = 0;
        ah[p] = 1;
        free_cnt -= 1 << o;
        live_base.push_back(p);
        live_ord.push_back(o);
        return ST_OK;
    endfunction

    function logic [1:0] return_block(int n, int base);
        int o, cur, bud, hi;
        if (base >= (1 << pool_ord) || !ah[base]) return ST_BADFREE;
        o = ord[base];
        if (o > pool_ord || (base & ((1 << o) - 1)) != 0 || log2_up(n) != o)
            return ST_BADFREE;
        ah[base] = 0;
        free_cnt += 1 << o;
        foreach (live_base[i])
            if (live_base[i] == base)
            begin
                live_base.delete(i);
                live_ord.delete(i);
                break;
            end
        cur = base;
        push(o, cur);
        fh[cur] = 1;
        while (o < pool_ord)
        begin
            bud = cur ^ (1 << o);
            if (!fh[bud] || ord[bud] != o) break;
            unlink(o, cur);
            unlink(o, bud);
            hi = (cur > bud) ? cur : bud;
            cur = (cur < bud) ? cur : bud;
            fh[hi] = 0;
            o++;
            ord[cur] = o;
            push(o, cur);
            fh[cur] = 1;
        end
        return ST_OK;
    endfunction

    function void note_request(req_t r);
        rsp_t e;
        int   n, p;
        n = int'(r.page_count);
        if (n == 0) n = 1;
        e = '0;
        if (r.cmd == CMD_ALLOC)
        begin
            e.status = take_block(n, p);
            if (e.status == ST_OK) e.block_index = 10'(p);
        end
        else
            e.status = return_block(n, int'(r.page_index));
        e.pages_left = 11'(free_cnt);
        pending_rsp.push_back(e);
    endfunction

    function void check_response(rsp_t a);
        rsp_t e;
        if (pending_rsp.size() == 0)
        begin
            $error("unexpected response %p", a);
            errors++;
            return;
        end
        e = pending_rsp.pop_front();
        if (a.status !== e.status)
        begin
            $error("status: expected %0d actual %0d", e.status, a.status);
            errors++;
        end
        if (a.block_index !== e.block_index)
        begin
            $error("block_index: expected %0d actual %0d", e.block_index, a.block_index);
            errors++;
        end
        if (a.pages_left !== e.pages_left)
        begin
            $error("pages_left: expected %0d actual %0d", e.pages_left, a.pages_left);
            errors++;
        end
    endfunction
endclass

module tb_buddy_page_allocator_top;
    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_stall;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_data;

    page_pool_model pool;
    int snd_idle;
    int rcv_idle;
    int hold_cycles;
    int quiet;

    localparam int QUIET_LIMIT = 6000;

    buddy_page_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1; #10;
        clk = 1'b0; #10;
    end

    // response side: random stall, long hold-off on request
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            rsp_stall = 1'b1;
        end
        else
            rsp_stall = ($urandom_range(0, 99) < rcv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            pool.check_response(rsp);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send(req_t r);
        @(negedge clk);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req = r;
        do @(posedge clk); while (req_stall);
        pool.note_request(r);
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic drain();
        while (pool.pending_rsp.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_pool_order(logic [3:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = v;
        do @(posedge clk); while (!cfg_ready);
        pool.reinit(int'(v));
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_op(logic c, int n, int idx);
        req_t r;
        r.cmd = c;
        r.page_count = 11'(n);
        r.page_index = 10'(idx);
        send(r);
    endtask

    task automatic send_random();
        req_t r;
        int   k, i, o;
        k = $urandom_range(0, 99);
        r.page_index = 10'($urandom_range(0, 1023));
        if (k < 50)
        begin
            r.cmd = CMD_ALLOC;
            r.page_count = (k < 44) ? 11'($urandom_range(0, 8))
                                    : 11'($urandom_range(0, 2047));
        end
        else if (k < 88 && pool.live_base.size() != 0)
        begin
            i = $urandom_range(0, pool.live_base.size() - 1);
            o = pool.live_ord[i];
            r.cmd = CMD_FREE;
            r.page_index = 10'(pool.live_base[i]);
            r.page_count = (o == 0) ? 11'($urandom_range(0, 1))
                                    : 11'($urandom_range((1 << (o - 1)) + 1, 1 << o));
            if (k >= 84) r.page_count = 11'((1 << o) * 2 + $urandom_range(0, 1));
        end
        else
        begin
            r.cmd = 1'($urandom_range(0, 1));
            r.page_count = 11'($urandom_range(0, 2047));
        end
        send(r);
    endtask

    initial
    begin
        logic [3:0] orders[6];
        pool = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        snd_idle = 18;
        rcv_idle = 74;
        hold_cycles = 0;
        quiet = 0;
        orders = '{4'd0, 4'd4, 4'd10, 4'd15, 4'd6, 4'd2};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, both commands, bad frees
        send_op(CMD_ALLOC, 1, 1023);
        send_op(CMD_ALLOC, 0, 0);
        send_op(CMD_ALLOC, 1024, 0);
        send_op(CMD_ALLOC, 2047, 1023);
        send_op(CMD_ALLOC, 3, 0);
        send_op(CMD_ALLOC, 513, 0);
        send_op(CMD_FREE, 1, 0);
        send_op(CMD_FREE, 1, 0);
        send_op(CMD_FREE, 2, 1);
        send_op(CMD_FREE, 1, 1023);
        send_op(CMD_FREE, 4, 4);
        send_op(CMD_FREE, 3, 4);
        send_op(CMD_FREE, 0, 1);
        send_op(CMD_ALLOC, 512, 0);
        send_op(CMD_ALLOC, 512, 0);
        send_op(CMD_ALLOC, 512, 0);
        send_op(CMD_FREE, 2047, 0);
        send_op(CMD_FREE, 512, 0);
        send_op(CMD_FREE, 512, 512);
        send_op(CMD_ALLOC, 1024, 0);
        send_op(CMD_FREE, 1024, 0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                snd_idle = 74;
                rcv_idle = 18;
            end
            if (ph == 4)
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            write_pool_order(orders[ph]);
            if (ph == 4)
            begin
                // receiver holds off while requests keep coming
                hold_cycles = 400;
                repeat (30) send_random();
                drain();
            end
            repeat (255) send_random();
            drain();
        end

        if (pool.errors == 0 && pool.pending_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

### filelist.f
src/bpa_pkg.sv
src/bpa_page_mem.sv
src/bpa_seq.sv
src/buddy_page_allocator_top.sv
tb/tb_buddy_page_allocator_top.sv
